>>> rtl/core/psrq_pkg.sv
package psrq_pkg;

  // fixed field widths
  localparam int LimitW = 16;
  localparam int CountW = 13;
  localparam int ValW   = 16;

  // opcodes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [1:0] STAT_BAD_RANGE = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [ValW-1:0]   range_low;
    logic [ValW-1:0]   range_high;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] prime_count;
    logic [ValW-1:0]   largest_prime;
    logic [1:0]        status;
  } out_item_t;

  // one entry of the count / last-prime table
  typedef struct packed {
    logic [CountW-1:0] prefix_count;
    logic [ValW-1:0]   last_prime;
  } tbl_entry_t;

  localparam int TblW = $bits(tbl_entry_t);

endpackage

>>> rtl/core/psrq_ram.sv
module psrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/prime_sieve_range_query_top.sv
// channel   ports                                  beat taken when
// ------    -----------------------------------    ----------------------------
// input     start, busy, in_item                   start && !busy
// result    out_strobe, out_item                   out_strobe (one cycle)
// config    cfg_wr_en, cfg_wr_data (limit)          cfg_wr_en
//
// a query passes through states Q1 and Q2 to its result (two table reads, each on the
// registered read port of the table memory); a query error comes back the next cycle
// a build makes (top+1) init writes, reads and checks each base up to sqrt(top),
// clears one crossed-off multiple per cycle (N log log N), then scans the table;
// init and cross-off are limited by the single write port of the flag memory
// reset (rst_n low, synchronous) clears control and marks the tables unbuilt;
// memories are not cleared; the receiver cannot stall the result strobe
module prime_sieve_range_query_top
  import psrq_pkg::*;
#(
  parameter int MAX_N = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_strobe,
  output out_item_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [LimitW-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_N);
  localparam int CW = (AW > LimitW) ? AW : LimitW;
  localparam int XW = CW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_SV_RD  = 3'd2;
  localparam logic [2:0] ST_SV_CHK = 3'd3;
  localparam logic [2:0] ST_CROSS  = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_Q1     = 3'd6;
  localparam logic [2:0] ST_Q2     = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [LimitW-1:0] limit_r;
  logic              built_r, built_nxt;
  logic [AW-1:0]     built_limit_r, built_limit_nxt;
  logic [XW-1:0]     idx_r, idx_nxt;
  logic [XW-1:0]     sq_r, sq_nxt;
  logic [XW-1:0]     j_r, j_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic [CountW-1:0] run_r, run_nxt;
  logic [ValW-1:0]   last_r, last_nxt;
  logic [ValW-1:0]   lo_r, lo_nxt;
  tbl_entry_t        hi_ent_r, hi_ent_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // memory ports
  logic              flag_we;
  logic [AW-1:0]     flag_waddr;
  logic              flag_wdata;
  logic [AW-1:0]     flag_raddr;
  logic              flag_rdata;
  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  tbl_entry_t        tbl_wdata;
  logic [AW-1:0]     tbl_raddr;
  logic [TblW-1:0]   tbl_rdata_raw;
  tbl_entry_t        tbl_rdata;

  // helpers
  logic [CW-1:0]     lim_ext;
  logic [CW-1:0]     top_cw;
  logic [XW-1:0]     top_x;
  logic              bad_range;
  logic [XW-1:0]     j_step;
  logic              scan_issue;
  logic [CountW-1:0] scan_run;
  logic [ValW-1:0]   scan_last;
  logic [CountW-1:0] q_count;
  logic [ValW-1:0]   q_biggest;

  psrq_ram #(.Width(1), .Depth(MAX_N)) u_flag_ram (
    .clk     (clk),
    .wr_en   (flag_we),
    .wr_addr (flag_waddr),
    .wr_data (flag_wdata),
    .rd_addr (flag_raddr),
    .rd_data (flag_rdata)
  );

  psrq_ram #(.Width(TblW), .Depth(MAX_N)) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata_raw)
  );

  assign tbl_rdata = tbl_rdata_raw;
  assign busy      = (state_r != ST_IDLE);

  // build top: limit cut down to the table size
  assign lim_ext = CW'(limit_r);
  assign top_cw  = (lim_ext > CW'(MAX_N - 1)) ? CW'(MAX_N - 1) : lim_ext;
  assign top_x   = XW'(built_limit_r);

  // query range check against the latched limit
  assign bad_range = (in_item.range_low == '0) ||
                     (CW'(in_item.range_high) > CW'(built_limit_r)) ||
                     (in_item.range_low > in_item.range_high);

  assign j_step     = j_r + idx_r;
  assign scan_issue = (idx_r <= top_x);
  assign scan_run   = run_r + CountW'(flag_rdata);
  assign scan_last  = flag_rdata ? ValW'(pend_idx_r) : last_r;

  // query result from the two table entries
  assign q_count   = hi_ent_r.prefix_count - tbl_rdata.prefix_count;
  assign q_biggest = (hi_ent_r.last_prime < lo_r) ? '0 : hi_ent_r.last_prime;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    built_nxt       = built_r;
    built_limit_nxt = built_limit_r;
    idx_nxt         = idx_r;
    sq_nxt          = sq_r;
    j_nxt           = j_r;
    pend_v_nxt      = pend_v_r;
    pend_idx_nxt    = pend_idx_r;
    run_nxt         = run_r;
    last_nxt        = last_r;
    lo_nxt          = lo_r;
    hi_ent_nxt      = hi_ent_r;
    out_strobe_nxt  = 1'b0;
    out_item_nxt    = out_item_r;
    flag_we         = 1'b0;
    flag_waddr      = idx_r[AW-1:0];
    flag_wdata      = 1'b0;
    flag_raddr      = idx_r[AW-1:0];
    tbl_we          = 1'b0;
    tbl_waddr       = pend_idx_r;
    tbl_wdata       = '{prefix_count: scan_run, last_prime: scan_last};
    tbl_raddr       = AW'(in_item.range_high);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.opcode == OP_BUILD) begin
            built_nxt       = 1'b1;
            built_limit_nxt = AW'(top_cw);
            idx_nxt         = '0;
            state_nxt       = ST_INIT;
          end else if (!built_r) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{prime_count: '0, largest_prime: '0, status: STAT_NOT_BUILT};
          end else if (bad_range) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{prime_count: '0, largest_prime: '0, status: STAT_BAD_RANGE};
          end else begin
            // table read at range_high goes out this cycle
            lo_nxt    = in_item.range_low;
            state_nxt = ST_Q1;
          end
        end
      end
      ST_INIT: begin
        // flags start as one from two upward
        flag_we    = 1'b1;
        flag_wdata = (idx_r >= XW'(2));
        if (idx_r == top_x) begin
          idx_nxt   = XW'(2);
          sq_nxt    = XW'(4);
          state_nxt = ST_SV_RD;
        end else begin
          idx_nxt = idx_r + XW'(1);
        end
      end
      ST_SV_RD: begin
        if (sq_r > top_x) begin
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          run_nxt    = '0;
          last_nxt   = '0;
          state_nxt  = ST_SCAN;
        end else begin
          state_nxt = ST_SV_CHK;
        end
      end
      ST_SV_CHK: begin
        if (flag_rdata) begin
          j_nxt     = sq_r;
          state_nxt = ST_CROSS;
        end else begin
          idx_nxt   = idx_r + XW'(1);
          sq_nxt    = sq_r + XW'({idx_r, 1'b1});
          state_nxt = ST_SV_RD;
        end
      end
      ST_CROSS: begin
        // clear one multiple a cycle
        flag_we    = 1'b1;
        flag_waddr = j_r[AW-1:0];
        flag_wdata = 1'b0;
        if (j_step > top_x) begin
          idx_nxt   = idx_r + XW'(1);
          sq_nxt    = sq_r + XW'({idx_r, 1'b1});
          state_nxt = ST_SV_RD;
        end else begin
          j_nxt = j_step;
        end
      end
      ST_SCAN: begin
        // read flag ahead, write running count and last prime in the next cycle
        if (scan_issue) begin
          idx_nxt = idx_r + XW'(1);
        end
        pend_v_nxt   = scan_issue;
        pend_idx_nxt = idx_r[AW-1:0];
        if (pend_v_r) begin
          tbl_we   = 1'b1;
          run_nxt  = scan_run;
          last_nxt = scan_last;
        end
        if (!scan_issue && !pend_v_r) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{prime_count: '0, largest_prime: '0, status: STAT_OK};
          state_nxt      = ST_IDLE;
        end
      end
      ST_Q1: begin
        hi_ent_nxt = tbl_rdata;
        tbl_raddr  = AW'(lo_r - ValW'(1));
        state_nxt  = ST_Q2;
      end
      ST_Q2: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt   = '{prime_count: q_count, largest_prime: q_biggest, status: STAT_OK};
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      limit_r       <= '1;
      built_r       <= 1'b0;
      built_limit_r <= '0;
      pend_v_r      <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      built_r       <= built_nxt;
      built_limit_r <= built_limit_nxt;
      pend_v_r      <= pend_v_nxt;
      out_strobe_r  <= out_strobe_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    sq_r       <= sq_nxt;
    j_r        <= j_nxt;
    pend_idx_r <= pend_idx_nxt;
    run_r      <= run_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_ent_r   <= hi_ent_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef NO_ASSERTIONS
  // query before any build answers on the next cycle with not-built
  a_not_built: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.opcode == OP_QUERY && !built_r)
      |=> (out_strobe && out_item.status == STAT_NOT_BUILT))
    else $error("not-built query did not answer");

  // second table read always ends in an ok result
  a_query_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q2) |=> (out_strobe && out_item.status == STAT_OK && !busy))
    else $error("query result missing");

  // an empty range has no largest prime and vice versa
  a_count_vs_largest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == STAT_OK)
      |-> ((out_item.prime_count == '0) == (out_item.largest_prime == '0)))
    else $error("prime count and largest prime disagree");

  // crossing off never writes past the built limit
  a_cross_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CROSS) |-> (j_r <= top_x))
    else $error("sieve write beyond limit");
`endif

endmodule
